/* rtl/tse_pkg.sv */
// Shared constants, register indexes and result type for the tab expander.
`default_nettype none

package tse_pkg;

  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_SPACE = 8'h20;

  localparam int STOP_BITS     = 16;
  localparam int CFG_DATA_BITS = 64;
  localparam int CFG_IDX_BITS  = 3;
  localparam int STOPS_PER_REG = CFG_DATA_BITS / STOP_BITS;
  localparam int CNT_BITS      = 5;

  localparam logic [STOP_BITS-1:0] STOP0_RESET     = 16'd8;
  localparam logic [CNT_BITS-1:0]  STOP_CNT_RESET  = 5'd1;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_LEAD_ONLY    = 3'd0,
    CFG_STOP_COUNT   = 3'd1,
    CFG_STOPS_0_3    = 3'd2,
    CFG_STOPS_4_7    = 3'd3,
    CFG_STOPS_8_11   = 3'd4,
    CFG_STOPS_12_15  = 3'd5
  } cfg_reg_t;

  // One processed byte: the byte and its repeat count, plus a flag for the
  // newline that closes a stream not already ending in one.
  typedef struct packed {
    logic [7:0]           out_byte;
    logic [STOP_BITS-1:0] run_length;
    logic                 extra_nl;
  } tse_result_t;

endpackage

`default_nettype wire

/* rtl/tab_to_space_expander.sv */
// Streaming tab expander: top level with config registers, line state and I/O stages.
//
// Input stream: one text byte per transaction on s_axis (tdata = byte,
// tlast = end of stream). Output stream: one run per transaction on m_axis
// (tdata = byte, repeat count), tlast on the final run caused by an input byte.
// A tab becomes a space run reaching the next stop (repeating interval when
// one stop is in use, else the first listed stop beyond the column); in
// initial-only mode a tab after a non-blank byte on the line stays a tab.
// Throughput: one input byte per cycle while the receiver keeps up. A stream
// end on a byte other than newline produces a second run (a single newline),
// sent from the same output register before the next byte can enter it.
// Each input byte passes through the input register, then the stop compare
// and column update into the output register.
// The receiver may stall at any time: the output register holds its run and
// the input register keeps accepting until it too holds a waiting byte.
// Reset: column 0, line marked all blank, phase 0, interval 8 with one stop,
// initial-only mode off, both stages empty.
// Configuration writes take effect at once and belong in idle periods.
`default_nettype none

module tab_to_space_expander #(
  parameter int STOP_SLOTS  = 16,
  parameter int COLUMN_BITS = 16
) (
  input  wire logic                                      clk,
  input  wire logic                                      rst,
  input  wire logic                                      cfg_wen,
  input  wire logic [tse_pkg::CFG_IDX_BITS-1:0]          cfg_index,
  input  wire logic [tse_pkg::CFG_DATA_BITS-1:0]         cfg_wdata,
  input  wire logic                                      s_axis_tvalid,
  output logic                                           s_axis_tready,
  input  wire logic [7:0]                                s_axis_tdata,  // in_byte
  input  wire logic                                      s_axis_tlast,  // end_of_stream
  output logic                                           m_axis_tvalid,
  input  wire logic                                      m_axis_tready,
  output logic [23:0]                                    m_axis_tdata,  // out_byte, run_length
  output logic                                           m_axis_tlast   // last
);

  localparam int SW = tse_pkg::STOP_BITS;

  // configuration
  logic                             lead_only;
  logic [tse_pkg::CNT_BITS-1:0]     stop_count;
  logic [STOP_SLOTS-1:0][SW-1:0]    stops;

  // line state
  logic [COLUMN_BITS-1:0]           column;
  logic                             leading_blanks;
  logic [SW-1:0]                    interval_phase;
  logic [COLUMN_BITS-1:0]           column_next;
  logic                             leading_blanks_next;
  logic [SW-1:0]                    interval_phase_next;

  // input register
  logic                             hold_valid;
  logic [7:0]                       hold_byte;
  logic                             hold_eos;

  // output register
  logic                             res_valid;
  logic [7:0]                       res_byte;
  logic [SW-1:0]                    res_run;
  logic                             res_extra;
  logic                             res_nl;

  tse_pkg::tse_result_t             step_res;
  logic                             advance;
  logic                             out_done;
  logic                             out_xfer;

  always_ff @(posedge clk) begin
    if (rst) begin
      lead_only    <= 1'b0;
      stop_count   <= tse_pkg::STOP_CNT_RESET;
    end else if (cfg_wen) begin
      case (tse_pkg::cfg_reg_t'(cfg_index))
        tse_pkg::CFG_LEAD_ONLY:  lead_only  <= cfg_wdata[0];
        tse_pkg::CFG_STOP_COUNT: stop_count <= cfg_wdata[tse_pkg::CNT_BITS-1:0];
        default: ;
      endcase
    end
  end

  // four stops per register, low lane first
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < STOP_SLOTS; i++) begin
        stops[i] <= (i == 0) ? tse_pkg::STOP0_RESET : '0;
      end
    end else if (cfg_wen) begin
      for (int i = 0; i < STOP_SLOTS; i++) begin
        if (cfg_index == tse_pkg::CFG_IDX_BITS'(
              tse_pkg::CFG_STOPS_0_3 + i / tse_pkg::STOPS_PER_REG)) begin
          stops[i] <= cfg_wdata[(i % tse_pkg::STOPS_PER_REG)*SW +: SW];
        end
      end
    end
  end

  assign out_xfer = m_axis_tvalid && m_axis_tready;
  assign out_done = out_xfer && m_axis_tlast;
  assign advance  = hold_valid && (!res_valid || out_done);
  assign s_axis_tready = !hold_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (s_axis_tready) begin
      hold_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      hold_byte <= s_axis_tdata;
      hold_eos  <= s_axis_tlast;
    end
  end

  tse_step #(
    .STOP_SLOTS  (STOP_SLOTS),
    .COLUMN_BITS (COLUMN_BITS)
  ) u_step (
    .lead_only           (lead_only),
    .stop_count          (stop_count),
    .stops               (stops),
    .column              (column),
    .leading_blanks      (leading_blanks),
    .interval_phase      (interval_phase),
    .in_byte             (hold_byte),
    .end_of_stream       (hold_eos),
    .result              (step_res),
    .column_next         (column_next),
    .leading_blanks_next (leading_blanks_next),
    .interval_phase_next (interval_phase_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      column         <= '0;
      leading_blanks <= 1'b1;
      interval_phase <= '0;
    end else if (advance) begin
      column         <= column_next;
      leading_blanks <= leading_blanks_next;
      interval_phase <= interval_phase_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
      res_nl    <= 1'b0;
    end else if (advance) begin
      res_valid <= 1'b1;
      res_nl    <= 1'b0;
    end else if (out_done) begin
      res_valid <= 1'b0;
      res_nl    <= 1'b0;
    end else if (out_xfer) begin
      // first run taken, closing newline follows
      res_nl <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_byte  <= step_res.out_byte;
      res_run   <= step_res.run_length;
      res_extra <= step_res.extra_nl;
    end
  end

  assign m_axis_tvalid = res_valid;
  assign m_axis_tlast  = res_nl || !res_extra;
  assign m_axis_tdata  = res_nl ? {SW'(1), tse_pkg::CH_NL} : {res_run, res_byte};

  a_nl_follows: assert property (@(posedge clk) disable iff (rst)
    (out_xfer && !m_axis_tlast) |=> (m_axis_tvalid && m_axis_tlast &&
                                     m_axis_tdata[7:0] == tse_pkg::CH_NL))
    else $error("closing newline did not follow first run");

  a_run_nonzero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tdata[23:8] != '0))
    else $error("zero run length");

  a_eos_resets_line: assert property (@(posedge clk) disable iff (rst)
    (advance && hold_eos) |=> (column == '0 && leading_blanks && interval_phase == '0))
    else $error("line state not cleared at end of stream");

  a_hold_kept: assert property (@(posedge clk) disable iff (rst)
    (hold_valid && !advance) |=> (hold_valid && $stable(hold_byte) && $stable(hold_eos)))
    else $error("waiting input byte lost");

endmodule

`default_nettype wire

/* rtl/tse_step.sv */
// Per-byte expansion logic: next tab stop, run length and next line state.
`default_nettype none

module tse_step #(
  parameter int STOP_SLOTS  = 16,
  parameter int COLUMN_BITS = 16
) (
  input  wire logic                                           lead_only,
  input  wire logic [tse_pkg::CNT_BITS-1:0]                   stop_count,
  input  wire logic [STOP_SLOTS-1:0][tse_pkg::STOP_BITS-1:0]  stops,
  input  wire logic [COLUMN_BITS-1:0]                         column,
  input  wire logic                                           leading_blanks,
  input  wire logic [tse_pkg::STOP_BITS-1:0]                  interval_phase,
  input  wire logic [7:0]                                     in_byte,
  input  wire logic                                           end_of_stream,
  output tse_pkg::tse_result_t                                result,
  output logic [COLUMN_BITS-1:0]                              column_next,
  output logic                                                leading_blanks_next,
  output logic [tse_pkg::STOP_BITS-1:0]                       interval_phase_next
);

  localparam int SW   = tse_pkg::STOP_BITS;
  localparam int CW   = tse_pkg::CNT_BITS;
  localparam int IDXW = $clog2(STOP_SLOTS);
  localparam logic [CW-1:0] SLOTS_N = CW'(STOP_SLOTS);
  localparam logic [SW:0]   COL_MAX = (SW+1)'((1 << COLUMN_BITS) - 1);

  logic [CW-1:0]         active;
  logic [SW-1:0]         col16;
  logic [SW-1:0]         width;
  logic [SW-1:0]         phase;
  logic [SW-1:0]         phase_inc;
  logic [SW-1:0]         d_int;
  logic [SW-1:0]         d_list;
  logic [SW-1:0]         tab_dist;
  logic [SW-1:0]         step;
  logic [SW:0]           col_sum;
  logic [COLUMN_BITS-1:0] col_adv;
  logic [STOP_SLOTS-1:0] hit;
  logic [IDXW-1:0]       sel;
  logic                  is_tab;
  logic                  is_nl;
  logic                  tab_literal;

  always_comb begin
    if (stop_count == '0) active = CW'(1);
    else if (stop_count > SLOTS_N) active = SLOTS_N;
    else active = stop_count;
  end

  assign col16 = SW'(column);

  // Repeating interval: distance comes from the running phase
  assign width     = (stops[0] == '0) ? SW'(1) : stops[0];
  assign phase     = (interval_phase < width) ? interval_phase : '0;
  assign d_int     = width - phase;
  assign phase_inc = phase + SW'(1);

  // Explicit stop list: first listed stop beyond the column
  always_comb begin
    for (int i = 0; i < STOP_SLOTS; i++) begin
      hit[i] = (CW'(i) < active) && (stops[i] > col16);
    end
    sel = '0;
    for (int i = STOP_SLOTS - 1; i >= 0; i--) begin
      if (hit[i]) sel = IDXW'(i);
    end
  end

  assign d_list   = (|hit) ? (stops[sel] - col16) : SW'(1);
  assign tab_dist = (active == CW'(1)) ? d_int : d_list;

  assign is_tab      = (in_byte == tse_pkg::CH_TAB);
  assign is_nl       = (in_byte == tse_pkg::CH_NL);
  assign tab_literal = lead_only && !leading_blanks;
  assign step        = is_tab ? tab_dist : SW'(1);

  // Column saturates at the top of its range
  assign col_sum = {1'b0, col16} + {1'b0, step};
  assign col_adv = (col_sum > COL_MAX) ? COLUMN_BITS'(COL_MAX) : COLUMN_BITS'(col_sum);

  always_comb begin
    result.extra_nl   = end_of_stream && !is_nl;
    result.out_byte   = in_byte;
    result.run_length = SW'(1);
    column_next         = col_adv;
    leading_blanks_next = leading_blanks;
    interval_phase_next = (phase_inc >= width) ? '0 : phase_inc;
    if (is_tab) begin
      interval_phase_next = '0;
      if (tab_literal) begin
        result.out_byte = tse_pkg::CH_TAB;
      end else begin
        result.out_byte   = tse_pkg::CH_SPACE;
        result.run_length = tab_dist;
      end
    end else if (is_nl) begin
      column_next         = '0;
      leading_blanks_next = 1'b1;
      interval_phase_next = '0;
    end else if (in_byte != tse_pkg::CH_SPACE) begin
      leading_blanks_next = 1'b0;
    end
    if (end_of_stream) begin
      column_next         = '0;
      leading_blanks_next = 1'b1;
      interval_phase_next = '0;
    end
  end

endmodule

`default_nettype wire
